>>> rtl/binary_min_heap_queue_defines.svh
// Assertion macros for the binary min-heap queue checker.
// Needs signals named clk and arst_n in the scope where a macro is used.
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMHQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("binary min-heap queue: check failed");

// Consequent must hold in the cycle after the antecedent.
`define BMHQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("binary min-heap queue: check failed");

`endif

>>> rtl/bmhq_pkg.sv
// Shared types and constants of the binary min-heap queue.
// No dependencies; imported by the level cell, the top level and the checker.
package bmhq_pkg;

	localparam int DEPTH_DEFAULT = 256;
	localparam int DATA_W        = 32;
	localparam int COUNT_OUT_W   = 8;
	localparam int SLOT_MAX_W    = 16;

	localparam logic signed [DATA_W-1:0] FLOOR_VALUE = -32'sd1;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_BELOW = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_LOAD,
		S_RUN,
		S_RESP
	} state_t;

	// Token handed from one level cell to the next
	typedef struct packed {
		logic valid;
		op_t  op;
	} tok_t;

	localparam tok_t TOK_IDLE = '{valid: 1'b0, op: OP_INSERT};

	// Position of the highest set bit; zero for a zero word
	function automatic logic [3:0] msb_pos(input logic [SLOT_MAX_W-1:0] v);
		logic [3:0] p;
		p = '0;
		for (int i = 0; i < SLOT_MAX_W; i++) begin
			if (v[i]) begin
				p = 4'(i);
			end
		end
		return p;
	endfunction

endpackage

>>> rtl/bmhq_level_cell.sv
// One tree level of the heap: its slot memory and the compare step for a passing token.
// Depends on bmhq_pkg; instantiated once per level by binary_min_heap_queue.
module bmhq_level_cell
	import bmhq_pkg::*;
#(
	parameter int LEVEL  = 0,
	parameter int LEVELS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tok_t                     tok_in,
	input  logic [LEVELS-2:0]        idx_in,
	input  logic [DATA_W-1:0]        val_in,
	input  tok_t                     par_tok,
	input  logic [LEVELS-2:0]        par_idx,
	input  logic [LEVELS-1:0]        ins_slot,
	input  logic [$clog2(LEVELS)-1:0] ins_lvl,
	input  logic [LEVELS-1:0]        fill,
	input  logic                     fetch,
	input  logic [$clog2(LEVELS)-1:0] fetch_lvl,
	input  logic [LEVELS-2:0]        fetch_idx,
	input  logic [DATA_W-1:0]        cld_a,
	input  logic [DATA_W-1:0]        cld_b,
	output logic [DATA_W-1:0]        rd_a,
	output logic [DATA_W-1:0]        rd_b,
	output tok_t                     tok_out,
	output logic [LEVELS-2:0]        idx_out,
	output logic [DATA_W-1:0]        val_out,
	output logic                     done
);

	localparam int AW = (LEVEL == 0) ? 1 : LEVEL;
	localparam int IW = LEVELS - 1;
	localparam int LW = $clog2(LEVELS);
	localparam int CW = LEVELS;
	localparam int SW = LEVELS + 1;

	logic [DATA_W-1:0] mem_q [2**LEVEL];
	logic [DATA_W-1:0] rd_a_q;
	logic [DATA_W-1:0] rd_b_q;

	logic              valid_s1;
	op_t               op_s1;
	logic [IW-1:0]     idx_s1;
	logic [DATA_W-1:0] val_s1;

	logic [CW-1:0]     ins_path;
	logic [AW-1:0]     ins_addr;
	logic              at_target;
	logic [AW-1:0]     addr_a;
	logic [AW-1:0]     addr_b;
	logic              we;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     own_addr;
	logic [DATA_W-1:0] wr_data;

	logic [SW-1:0]     left_slot;
	logic [SW-1:0]     right_slot;
	logic              has_left;
	logic              has_right;
	logic              take_right;
	logic              leaf_gt;
	logic [DATA_W-1:0] chosen;

	// Path of the insert slot at this level
	assign ins_path  = ins_slot >> (ins_lvl - LW'(LEVEL));
	assign ins_addr  = (LEVEL == 0) ? '0 : AW'(ins_path);
	assign at_target = (ins_lvl == LW'(LEVEL));
	assign own_addr  = (LEVEL == 0) ? '0 : AW'(idx_s1);

	always_comb begin
		if (LEVEL == 0) begin
			addr_a = '0;
		end else if (tok_in.valid && tok_in.op == OP_INSERT) begin
			addr_a = ins_addr;
		end else if (par_tok.valid && par_tok.op == OP_REMOVE) begin
			addr_a = AW'({par_idx, 1'b0});
		end else if (fetch && fetch_lvl == LW'(LEVEL)) begin
			addr_a = AW'(fetch_idx);
		end else begin
			addr_a = '0;
		end
	end

	always_comb begin
		if (LEVEL != 0 && par_tok.valid && par_tok.op == OP_REMOVE) begin
			addr_b = AW'({par_idx, 1'b1});
		end else begin
			addr_b = '0;
		end
	end

	always_ff @(posedge clk) begin
		rd_a_q <= mem_q[addr_a];
		rd_b_q <= mem_q[addr_b];
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid) begin
			op_s1  <= tok_in.op;
			idx_s1 <= idx_in;
			val_s1 <= val_in;
		end
	end

	// Children of this slot sit one level down; last level never has any
	assign left_slot  = (SW'(1) << (LEVEL + 1)) | (SW'(idx_s1) << 1);
	assign right_slot = left_slot | SW'(1);
	assign has_left   = (left_slot <= SW'(fill));
	assign has_right  = (right_slot <= SW'(fill));
	assign take_right = has_right && ($signed(cld_a) > $signed(cld_b));
	assign chosen     = take_right ? cld_b : cld_a;
	assign leaf_gt    = take_right ? ($signed(val_s1) > $signed(cld_b))
	                               : ($signed(val_s1) > $signed(cld_a));

	always_comb begin
		we      = 1'b0;
		wr_addr = own_addr;
		wr_data = val_s1;
		tok_out = TOK_IDLE;
		idx_out = idx_s1;
		val_out = val_s1;
		done    = 1'b0;
		if (valid_s1) begin
			case (op_s1)
				OP_INSERT: begin
					wr_addr = ins_addr;
					if (at_target) begin
						we   = 1'b1;
						done = 1'b1;
					end else begin
						tok_out = '{valid: 1'b1, op: OP_INSERT};
						if ($signed(val_s1) < $signed(rd_a_q)) begin
							we      = 1'b1;
							val_out = rd_a_q;
						end
					end
				end
				OP_REMOVE: begin
					we = 1'b1;
					if (has_left && leaf_gt) begin
						wr_data = chosen;
						tok_out = '{valid: 1'b1, op: OP_REMOVE};
						idx_out = IW'({idx_s1, take_right});
					end else begin
						done = 1'b1;
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
		end
	end

endmodule

>>> rtl/binary_min_heap_queue.sv
// Binary min-heap priority queue: top level with sequencer and the row of level cells.
// Depends on bmhq_pkg and bmhq_level_cell.
//
// Usage
//  Input words arrive on s_t*: s_tuser carries the operation (insert or remove smallest),
//  s_tdata the signed 32-bit value to insert (ignored on remove).
//  Every input word yields one result word on m_t*: m_tdata holds the removed value and
//  the number of values held afterwards, m_tuser the status code.
//  One word is worked on at a time; s_tready is high only while the sequencer is idle.
//  A result waits in an output register, so the next word is taken while it is unread.
//  Timing: the heap walk runs one tree level a cycle through the row of level cells,
//  each cell reading its own slot memory with a registered read.
//  A remove first fetches the root and the last slot (S_FETCH, then S_LOAD) before its
//  walk; refused words and removes on an empty heap go straight to the result state.
//  Reset empties the heap at once (only the fill count is cleared; slot memories hold
//  whatever they had and are never read above the fill level).
//  When the receiver stalls, the result word holds on m_t* and, once the next word is
//  finished, the sequencer waits with s_tready low until the output register frees.
module binary_min_heap_queue
	import bmhq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [0:0]  s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] removed_value, [39:32] item_count
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int LEVELS = $clog2(DEPTH);
	localparam int CW     = LEVELS;
	localparam int IW     = LEVELS - 1;
	localparam int LW     = $clog2(LEVELS);
	localparam logic [CW-1:0] CAP = CW'(DEPTH - 1);

	state_t state_q, state_d;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_inc;
	logic [CW-1:0]     leaf_full;
	logic [LW-1:0]     count_msb;
	logic [CW-1:0]     ins_slot_q;
	logic [LW-1:0]     ins_lvl_q;
	logic [LW-1:0]     leaf_lvl_q;
	logic [IW-1:0]     leaf_idx_q;

	logic              launch_q;
	op_t               launch_op_q;
	logic [DATA_W-1:0] launch_val_q;

	logic [DATA_W-1:0] res_val_q;
	status_t           res_st_q;

	logic                   out_valid_q;
	logic [DATA_W-1:0]      out_val_q;
	status_t                out_st_q;
	logic [COUNT_OUT_W-1:0] out_cnt_q;
	logic [CW+COUNT_OUT_W-1:0] cnt_ext;

	logic accept;
	logic ins_full;
	logic ins_below;
	logic out_free;
	logic op_done;

	// Chain between the level cells
	tok_t              tok_c   [LEVELS+1];
	logic [IW-1:0]     idx_c   [LEVELS+1];
	logic [DATA_W-1:0] val_c   [LEVELS+1];
	tok_t              par_tok [LEVELS];
	logic [IW-1:0]     par_idx [LEVELS];
	logic [DATA_W-1:0] rd_a_c  [LEVELS];
	logic [DATA_W-1:0] rd_b_c  [LEVELS];
	logic [DATA_W-1:0] cld_a   [LEVELS];
	logic [DATA_W-1:0] cld_b   [LEVELS];
	logic [LEVELS-1:0] done_c;

	assign accept    = (state_q == S_IDLE) && s_tvalid;
	assign s_tready  = (state_q == S_IDLE);
	assign ins_full  = (count_q == CAP);
	assign ins_below = ($signed(s_tdata) < FLOOR_VALUE);
	assign out_free  = !out_valid_q || m_tready;
	// A token running off the last cell also ends the walk
	assign op_done   = (|done_c) || tok_c[LEVELS].valid;

	assign count_inc = count_q + CW'(1);
	assign count_msb = LW'(msb_pos(SLOT_MAX_W'(count_q)));
	// Clear the top bit to get the last slot's place within its level
	assign leaf_full = count_q ^ (CW'(1) << count_msb);
	assign cnt_ext   = {{COUNT_OUT_W{1'b0}}, count_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == OP_INSERT) begin
						state_d = (ins_full || ins_below) ? S_RESP : S_RUN;
					end else begin
						state_d = (count_q == '0) ? S_RESP : S_FETCH;
					end
				end
			end
			S_FETCH: begin
				state_d = S_LOAD;
			end
			S_LOAD: begin
				state_d = (count_q == '0) ? S_RESP : S_RUN;
			end
			S_RUN: begin
				if (op_done) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control: fill count, token launch, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Launch a walk for an accepted insert that is not refused, or once a remove has its operands and values remain
			launch_q <= (accept && s_tuser == OP_INSERT && !ins_full && !ins_below)
				|| (state_q == S_LOAD && count_q != '0);
			if (accept) begin
				if (s_tuser == OP_INSERT) begin
					if (!ins_full && !ins_below) begin
						count_q <= count_inc;
					end
				end else if (count_q != '0) begin
					count_q <= count_q - CW'(1);
				end
			end
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: hold the operands of the walk and the pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			if (s_tuser == OP_INSERT) begin
				res_val_q    <= '0;
				res_st_q     <= ins_full ? STAT_FULL : (ins_below ? STAT_BELOW : STAT_OK);
				ins_slot_q   <= count_inc;
				ins_lvl_q    <= LW'(msb_pos(SLOT_MAX_W'(count_inc)));
				launch_op_q  <= OP_INSERT;
				launch_val_q <= s_tdata;
			end else begin
				res_val_q  <= FLOOR_VALUE;
				res_st_q   <= (count_q == '0) ? STAT_EMPTY : STAT_OK;
				leaf_lvl_q <= count_msb;
				leaf_idx_q <= IW'(leaf_full);
			end
		end
		if (state_q == S_LOAD) begin
			res_val_q    <= rd_b_c[0];
			launch_op_q  <= OP_REMOVE;
			launch_val_q <= rd_a_c[leaf_lvl_q];
		end
		if (state_q == S_RESP && out_free) begin
			out_val_q <= res_val_q;
			out_st_q  <= res_st_q;
			out_cnt_q <= cnt_ext[COUNT_OUT_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_cnt_q, out_val_q};
	assign m_tuser  = out_st_q;

	// Every walk enters at the root cell
	assign tok_c[0] = '{valid: launch_q, op: launch_op_q};
	assign idx_c[0] = '0;
	assign val_c[0] = launch_val_q;

	for (genvar k = 0; k < LEVELS; k++) begin : g_level
		if (k == 0) begin : g_root
			assign par_tok[k] = TOK_IDLE;
			assign par_idx[k] = '0;
		end else begin : g_inner
			assign par_tok[k] = tok_c[k-1];
			assign par_idx[k] = idx_c[k-1];
		end

		if (k == LEVELS - 1) begin : g_bottom
			assign cld_a[k] = '0;
			assign cld_b[k] = '0;
		end else begin : g_upper
			assign cld_a[k] = rd_a_c[k+1];
			assign cld_b[k] = rd_b_c[k+1];
		end

		bmhq_level_cell #(
			.LEVEL  (k),
			.LEVELS (LEVELS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tok_in    (tok_c[k]),
			.idx_in    (idx_c[k]),
			.val_in    (val_c[k]),
			.par_tok   (par_tok[k]),
			.par_idx   (par_idx[k]),
			.ins_slot  (ins_slot_q),
			.ins_lvl   (ins_lvl_q),
			.fill      (count_q),
			.fetch     (state_q == S_FETCH),
			.fetch_lvl (leaf_lvl_q),
			.fetch_idx (leaf_idx_q),
			.cld_a     (cld_a[k]),
			.cld_b     (cld_b[k]),
			.rd_a      (rd_a_c[k]),
			.rd_b      (rd_b_c[k]),
			.tok_out   (tok_c[k+1]),
			.idx_out   (idx_c[k+1]),
			.val_out   (val_c[k+1]),
			.done      (done_c[k])
		);
	end

endmodule

>>> rtl/bmhq_checker.sv
// Port-level checks of the binary min-heap queue, bound to the top level.
// Depends on bmhq_pkg and binary_min_heap_queue_defines.svh.
`include "binary_min_heap_queue_defines.svh"

module bmhq_checker
	import bmhq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,   // [31:0] value
	input logic [0:0]  s_tuser,   // [0] mode
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,   // [31:0] removed_value, [39:32] item_count
	input logic [1:0]  m_tuser    // [1:0] status
);

	localparam logic [COUNT_OUT_W-1:0] CAP_LOW = COUNT_OUT_W'((DEPTH - 1) % 256);

	// Stalled result word holds
	`BMHQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// One word in flight: ready drops straight after a word is taken
	`BMHQ_ASSERT_NEXT(a_single_word, s_tvalid && s_tready, !s_tready)

	// Empty remove reports minus one and no values held
	`BMHQ_ASSERT_SAME(a_empty_word, m_tvalid && m_tuser == STAT_EMPTY, m_tdata[31:0] == 32'hFFFF_FFFF && m_tdata[39:32] == 8'd0)

	// Refused insert on a full heap reports the capacity
	`BMHQ_ASSERT_SAME(a_full_word, m_tvalid && m_tuser == STAT_FULL, m_tdata[39:32] == CAP_LOW && m_tdata[31:0] == 32'd0)

	// Ports not covered by a check above
	logic unused_in;
	assign unused_in = ^{s_tdata, s_tuser};

endmodule

bind binary_min_heap_queue bmhq_checker #(
	.DEPTH (DEPTH)
) u_bmhq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
